// ----- rtl/pcf_pkg.sv -----
// shared constants, types and tap table for the pitch comb postfilter
// no dependencies
package pcf_pkg;

  localparam int unsigned MAX_PERIOD  = 1024;
  localparam int unsigned MIN_PERIOD  = 15;
  localparam int unsigned OVERLAP_MAX = 128;
  localparam int unsigned OVL_RESET   = 120;
  localparam int unsigned HIST_DEPTH  = MAX_PERIOD + 3;
  localparam int unsigned HAW         = $clog2(HIST_DEPTH);
  localparam int unsigned NTAP        = 5;

  typedef logic [HAW-1:0]     hist_addr_t;
  typedef logic signed [15:0] smp_t;
  typedef logic [14:0]        q15_t;
  typedef logic signed [16:0] tsum_t;
  typedef logic signed [17:0] term_t;

  // Q15 tap-shape table, rows indexed by tapset (0..2)
  function automatic q15_t tap_coef(input logic [1:0] row, input logic [1:0] k);
    q15_t c;
    c = '0;
    unique case (row)
      2'd0: begin
        unique case (k)
          2'd0: c = 15'd10048;
          2'd1: c = 15'd7112;
          default: c = 15'd4248;
        endcase
      end
      2'd1: begin
        unique case (k)
          2'd0: c = 15'd15200;
          2'd1: c = 15'd8784;
          default: c = 15'd0;
        endcase
      end
      default: begin
        unique case (k)
          2'd0: c = 15'd26208;
          2'd1: c = 15'd3280;
          default: c = 15'd0;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/pitch_comb_postfilter.sv -----
// Five-tap pitch comb postfilter over the block's own input history.
// Input words arrive on the s_axis group, one sample with its frame position,
// old and new period, Q15 gains and tap sets. Each accepted word yields one
// result word on m_axis: the filtered sample in tdata, the clip flag in tuser.
// Throughput: one word per cycle while the receiver does not stall. Pipeline:
// five register stages, the first loaded at the accepting edge.
// Ten history reads per word come from five replicated history
// memories, each with two read ports, all written with the incoming sample.
// The overlap length register is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while the block is idle, the block itself does not enforce this.
// Reset clears all valid bits, the write pointer and the fill count, and
// loads overlap length 120; history entries not yet written read as zero by
// comparing each tap lag with the fill count, so no clearing pass is needed.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops; nothing is lost or repeated.
// depends on pcf_pkg, pcf_hist, pcf_gain
module pitch_comb_postfilter
  import pcf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sample[15:0] window_value[30:16] sample_index[40:31] old_period[51:41]
  // new_period[62:52] old_gain[77:63] new_gain[92:78] old_tapset[94:93]
  // new_tapset[96:95], zero pad above
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // filtered_sample[15:0]
  output logic [15:0]  m_axis_tdata,
  // saturated[0]
  output logic         m_axis_tuser
);

  logic       en, acc;
  logic [7:0] ovl_q;
  hist_addr_t wr_q;
  logic [HAW-1:0] fill_q;

  smp_t        x_in;
  q15_t        w_in, g0_in, g1_in;
  logic [9:0]  pos_in;
  logic [10:0] t0_raw, t1_raw, t0c, t1c;
  logic [1:0]  ts0_in, ts1_in;
  logic [7:0]  ovl_eff;
  logic        xf_in;

  hist_addr_t  ra0 [NTAP];
  hist_addr_t  ra1 [NTAP];
  logic [NTAP-1:0] ok0, ok1;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  assign x_in   = s_axis_tdata[15:0];
  assign w_in   = s_axis_tdata[30:16];
  assign pos_in = s_axis_tdata[40:31];
  assign t0_raw = s_axis_tdata[51:41];
  assign t1_raw = s_axis_tdata[62:52];
  assign g0_in  = s_axis_tdata[77:63];
  assign g1_in  = s_axis_tdata[92:78];
  assign ts0_in = (s_axis_tdata[94:93] == 2'd3) ? 2'd2 : s_axis_tdata[94:93];
  assign ts1_in = (s_axis_tdata[96:95] == 2'd3) ? 2'd2 : s_axis_tdata[96:95];

  function automatic logic [10:0] clamp_t(input logic [10:0] p);
    if (p < 11'(MIN_PERIOD)) return 11'(MIN_PERIOD);
    if (p > 11'(MAX_PERIOD)) return 11'(MAX_PERIOD);
    return p;
  endfunction

  // wr - lag modulo depth, lag in 1 .. depth-1
  function automatic hist_addr_t lag_addr(input hist_addr_t wr, input logic [HAW:0] lag);
    logic [HAW:0] s;
    s = {1'b0, wr} + (HAW+1)'(HIST_DEPTH) - lag;
    if (s >= (HAW+1)'(HIST_DEPTH)) s = s - (HAW+1)'(HIST_DEPTH);
    return s[HAW-1:0];
  endfunction

  assign t0c     = clamp_t(t0_raw);
  assign t1c     = clamp_t(t1_raw);
  assign ovl_eff = (ovl_q > 8'(OVERLAP_MAX)) ? 8'(OVERLAP_MAX) : ovl_q;
  assign xf_in   = !(g0_in == g1_in && t0c == t1c && ts0_in == ts1_in)
                   && ({2'b0, ovl_eff} > pos_in);

  always_comb begin
    for (int k = 0; k < NTAP; k++) begin
      logic [HAW:0] l0, l1;
      l0 = (HAW+1)'(t0c) + (HAW+1)'(k) - (HAW+1)'(2);
      l1 = (HAW+1)'(t1c) + (HAW+1)'(k) - (HAW+1)'(2);
      ra0[k] = lag_addr(wr_q, l0);
      ra1[k] = lag_addr(wr_q, l1);
      ok0[k] = l0 <= {1'b0, fill_q};
      ok1[k] = l1 <= {1'b0, fill_q};
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovl_q  <= 8'(OVL_RESET);
      wr_q   <= '0;
      fill_q <= '0;
    end else begin
      if (cfg_we_i) begin
        ovl_q <= cfg_wdata_i;
      end
      if (acc) begin
        wr_q <= (wr_q == HAW'(HIST_DEPTH - 1)) ? '0 : wr_q + 1'b1;
        if (fill_q != HAW'(HIST_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // history copies, tap k of both filters per copy
  smp_t h0 [NTAP];
  smp_t h1 [NTAP];

  for (genvar k = 0; k < NTAP; k++) begin : g_hist
    pcf_hist u_hist (
      .clk_i     (clk_i),
      .we_i      (acc),
      .waddr_i   (wr_q),
      .wdata_i   (x_in),
      .re_i      (en),
      .raddr_a_i (ra0[k]),
      .raddr_b_i (ra1[k]),
      .rdata_a_o (h0[k]),
      .rdata_b_o (h1[k])
    );
  end

  // stage 1
  logic        v1_q;
  smp_t        x1_q;
  q15_t        w1_q, g01_q, g11_q;
  logic [1:0]  ts01_q, ts11_q;
  logic        xf1_q;
  logic [NTAP-1:0] ok0_q, ok1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= x_in;
      w1_q   <= w_in;
      g01_q  <= g0_in;
      g11_q  <= g1_in;
      ts01_q <= ts0_in;
      ts11_q <= ts1_in;
      xf1_q  <= xf_in;
      ok0_q  <= ok0;
      ok1_q  <= ok1;
    end
  end

  // stage 2: masked tap sums
  smp_t  m0 [NTAP];
  smp_t  m1 [NTAP];
  tsum_t c0_q, c1_q, a0_q, a1_q, b0_q, b1_q;
  smp_t  x2_q;
  logic  v2_q;

  always_comb begin
    for (int k = 0; k < NTAP; k++) begin
      m0[k] = ok0_q[k] ? h0[k] : '0;
      m1[k] = ok1_q[k] ? h1[k] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q <= 17'(m0[2]);
      c1_q <= 17'(m1[2]);
      a0_q <= 17'(m0[1]) + 17'(m0[3]);
      a1_q <= 17'(m1[1]) + 17'(m1[3]);
      b0_q <= 17'(m0[0]) + 17'(m0[4]);
      b1_q <= 17'(m1[0]) + 17'(m1[4]);
      x2_q <= x1_q;
    end
  end

  q15_t wo [3];
  q15_t wn [3];

  pcf_gain u_gain (
    .clk_i   (clk_i),
    .en_i    (en),
    .gain0_i (g01_q),
    .gain1_i (g11_q),
    .ts0_i   (ts01_q),
    .ts1_i   (ts11_q),
    .win_i   (w1_q),
    .xf_i    (xf1_q),
    .wo_o    (wo),
    .wn_o    (wn)
  );

  // stage 3: sums wait for weights
  tsum_t s0_q [3];
  tsum_t s1_q [3];
  smp_t  x3_q;
  logic  v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q[0] <= c0_q; s0_q[1] <= a0_q; s0_q[2] <= b0_q;
      s1_q[0] <= c1_q; s1_q[1] <= a1_q; s1_q[2] <= b1_q;
      x3_q    <= x2_q;
    end
  end

  // stage 4: weighted terms, floor shift
  logic signed [32:0] pr0 [3];
  logic signed [32:0] pr1 [3];
  term_t tm0_q [3];
  term_t tm1_q [3];
  smp_t  x4_q;
  logic  v4_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr0[k] = 33'(signed'({1'b0, wo[k]})) * 33'(s0_q[k]);
      pr1[k] = 33'(signed'({1'b0, wn[k]})) * 33'(s1_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        tm0_q[k] <= pr0[k][32:15];
        tm1_q[k] <= pr1[k][32:15];
      end
      x4_q <= x3_q;
    end
  end

  // output stage: sum and saturate
  logic signed [21:0] ysum;
  smp_t y_q;
  logic sat_q, ov_q;

  always_comb begin
    ysum = 22'(x4_q);
    for (int k = 0; k < 3; k++) begin
      ysum = ysum + 22'(tm0_q[k]) + 22'(tm1_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ysum > 22'sd32767) begin
        y_q   <= 16'sh7fff;
        sat_q <= 1'b1;
      end else if (ysum < -22'sd32768) begin
        y_q   <= 16'sh8000;
        sat_q <= 1'b1;
      end else begin
        y_q   <= ysum[15:0];
        sat_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ov_q <= v4_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = y_q;
  assign m_axis_tuser  = sat_q;

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q < HAW'(HIST_DEPTH)) else $error("history write pointer out of range");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= HAW'(HIST_DEPTH)) else $error("fill count beyond depth");

  a_wr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && wr_q != HAW'(HIST_DEPTH - 1) |=> wr_q == $past(wr_q) + 1'b1)
    else $error("write pointer did not advance on accept");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> y_q == 16'sh7fff || y_q == 16'sh8000)
    else $error("clip flag without clipped value");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v4_q) && $stable(v1_q))
    else $error("pipeline moved during stall");

endmodule

// ----- rtl/pcf_hist.sv -----
// one copy of the input history memory, one write port, two registered read ports
// depends on pcf_pkg
module pcf_hist
  import pcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       we_i,
  input  hist_addr_t waddr_i,
  input  smp_t       wdata_i,
  input  logic       re_i,
  input  hist_addr_t raddr_a_i,
  input  hist_addr_t raddr_b_i,
  output smp_t       rdata_a_o,
  output smp_t       rdata_b_o
);

  smp_t mem [HIST_DEPTH];
  smp_t rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= mem[raddr_a_i];
      rd_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

// ----- rtl/pcf_gain.sv -----
// two-stage tap weight pipeline: table gains and fade weight, then faded weights
// depends on pcf_pkg
module pcf_gain
  import pcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  q15_t       gain0_i,
  input  q15_t       gain1_i,
  input  logic [1:0] ts0_i,
  input  logic [1:0] ts1_i,
  input  q15_t       win_i,
  input  logic       xf_i,
  output q15_t       wo_o [3],
  output q15_t       wn_o [3]
);

  q15_t g0_q [3];
  q15_t g1_q [3];
  q15_t f_q;
  logic xf_q;
  q15_t wo_q [3];
  q15_t wn_q [3];

  logic [29:0] ww;
  logic [30:0] p0 [3];
  logic [30:0] p1 [3];
  q15_t        fo;
  logic [29:0] m0 [3];
  logic [29:0] m1 [3];

  always_comb begin
    ww = 30'(win_i) * 30'(win_i);
    for (int k = 0; k < 3; k++) begin
      p0[k] = 31'(gain0_i) * 31'(tap_coef(ts0_i, 2'(k))) + 31'd16384;
      p1[k] = 31'(gain1_i) * 31'(tap_coef(ts1_i, 2'(k))) + 31'd16384;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        g0_q[k] <= p0[k][29:15];
        g1_q[k] <= p1[k][29:15];
      end
      f_q  <= ww[29:15];
      xf_q <= xf_i;
    end
  end

  always_comb begin
    fo = 15'h7fff - f_q;
    for (int k = 0; k < 3; k++) begin
      m0[k] = 30'(fo) * 30'(g0_q[k]);
      m1[k] = 30'(f_q) * 30'(g1_q[k]);
    end
  end

  // outside the fade only the new filter acts, at its full gain
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        wo_q[k] <= xf_q ? m0[k][29:15] : '0;
        wn_q[k] <= xf_q ? m1[k][29:15] : g1_q[k];
      end
    end
  end

  assign wo_o = wo_q;
  assign wn_o = wn_q;

endmodule
